### rtl/core/mts_pkg.sv
// shared types and constants for the min tracking stack
package mts_pkg;

    localparam int STACK_DEPTH = 256;
    localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
    localparam int WORD_W      = 32;
    localparam int COUNT_W     = 9;

    typedef enum logic [0:0] {
        FUNC_PUSH = 1'b0,
        FUNC_POP  = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_POP_EMPTY = 2'd1,
        ST_PUSH_FULL = 2'd2
    } t_status;

    typedef logic [WORD_W-1:0]  t_word;
    typedef logic [DEPTH_W-1:0] t_depth;

    typedef struct packed {
        t_func              func;
        logic signed [31:0] push_value;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] top_value;
        logic signed [31:0] min_value;
        logic [COUNT_W-1:0] entry_count;
        logic               is_empty;
        t_status            status;
    } t_out_item;

    typedef struct packed {
        logic push;
        logic pop;
    } t_shift;

endpackage

### rtl/core/mts_cell.sv
// one stack cell: holds a word and shifts toward the top or the bottom
module mts_cell (
    input  logic           i_clk,
    input  mts_pkg::t_shift i_ctrl,
    input  mts_pkg::t_word i_prev_word,
    input  mts_pkg::t_word i_next_word,
    output mts_pkg::t_word o_word
);
    import mts_pkg::*;

    t_word r_word;
    t_word n_word;

    always_comb begin
        if (i_ctrl.push) begin
            n_word = i_prev_word;
        end else if (i_ctrl.pop) begin
            n_word = i_next_word;
        end else begin
            n_word = r_word;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule

### rtl/core/mts_chain.sv
// row of stack cells with the top at cell zero
module mts_chain (
    input  logic            i_clk,
    input  mts_pkg::t_shift i_ctrl,
    input  mts_pkg::t_word  i_push_word,
    output mts_pkg::t_word  o_top_word
);
    import mts_pkg::*;

    t_word w_word [STACK_DEPTH];

    for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
        t_word w_prev;
        t_word w_next;

        if (g == 0) begin : g_first
            assign w_prev = i_push_word;
        end else begin : g_mid
            assign w_prev = w_word[g-1];
        end

        if (g == STACK_DEPTH - 1) begin : g_last
            assign w_next = '0;
        end else begin : g_inner
            assign w_next = w_word[g+1];
        end

        mts_cell u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (i_ctrl),
            .i_prev_word (w_prev),
            .i_next_word (w_next),
            .o_word      (w_word[g])
        );
    end

    assign o_top_word = w_word[0];

endmodule

### rtl/core/min_tracking_stack.sv
// top level: value stack and minimum stack as shifting cell rows
// the cell rows shift when an item is accepted, and the top cells are read into
// the output register in the following cycle; no new item is taken while that
// work is under way, and a stalled result item holds off the next input item
// reset: depths cleared, no item pending; cell contents are not reset
module min_tracking_stack (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  mts_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output mts_pkg::t_out_item  o_out_item
);
    import mts_pkg::*;

    t_depth    r_vdepth;
    t_depth    n_vdepth;
    t_depth    r_mdepth;
    t_depth    n_mdepth;
    logic      r_busy;
    logic      r_out_valid;
    t_status   r_status;
    t_status   n_status;
    t_out_item r_out;

    logic   w_in_acc;
    t_shift w_vctrl;
    t_shift w_mctrl;
    t_word  w_vtop;
    t_word  w_mtop;
    logic   w_vfull;
    logic   w_vempty;
    logic   w_mfull;
    logic   w_mempty;
    logic   w_le;

    assign o_in_stall  = r_busy || (r_out_valid && i_out_stall);
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assign w_vfull  = (r_vdepth == DEPTH_W'(STACK_DEPTH));
    assign w_vempty = (r_vdepth == '0);
    assign w_mfull  = (r_mdepth == DEPTH_W'(STACK_DEPTH));
    assign w_mempty = (r_mdepth == '0);
    assign w_le     = ($signed(i_in_item.push_value) <= $signed(w_mtop));

    always_comb begin
        w_vctrl.push = w_in_acc && (i_in_item.func == FUNC_PUSH) && !w_vfull;
        w_vctrl.pop  = w_in_acc && (i_in_item.func == FUNC_POP) && !w_vempty;
        w_mctrl.push = w_vctrl.push && (w_mempty || w_le) && !w_mfull;
        w_mctrl.pop  = w_vctrl.pop && !w_mempty && (w_vtop == w_mtop);
    end

    always_comb begin
        n_vdepth = r_vdepth;
        n_mdepth = r_mdepth;
        n_status = r_status;
        if (w_vctrl.push) begin
            n_vdepth = r_vdepth + DEPTH_W'(1);
        end else if (w_vctrl.pop) begin
            n_vdepth = r_vdepth - DEPTH_W'(1);
        end
        if (w_mctrl.push) begin
            n_mdepth = r_mdepth + DEPTH_W'(1);
        end else if (w_mctrl.pop) begin
            n_mdepth = r_mdepth - DEPTH_W'(1);
        end
        if (w_in_acc) begin
            if (i_in_item.func == FUNC_PUSH) begin
                n_status = w_vfull ? ST_PUSH_FULL : ST_OK;
            end else begin
                n_status = w_vempty ? ST_POP_EMPTY : ST_OK;
            end
        end
    end

    mts_chain u_value_chain (
        .i_clk       (i_clk),
        .i_ctrl      (w_vctrl),
        .i_push_word (t_word'(i_in_item.push_value)),
        .o_top_word  (w_vtop)
    );

    mts_chain u_min_chain (
        .i_clk       (i_clk),
        .i_ctrl      (w_mctrl),
        .i_push_word (t_word'(i_in_item.push_value)),
        .o_top_word  (w_mtop)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vdepth    <= '0;
            r_mdepth    <= '0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_status    <= ST_OK;
        end else begin
            r_vdepth <= n_vdepth;
            r_mdepth <= n_mdepth;
            r_status <= n_status;
            r_busy   <= w_in_acc;
            if (r_busy) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_out.top_value   <= w_vempty ? '0 : $signed(w_vtop);
            r_out.min_value   <= (w_vempty || w_mempty) ? '0 : $signed(w_mtop);
            r_out.entry_count <= COUNT_W'(r_vdepth);
            r_out.is_empty    <= w_vempty;
            r_out.status      <= r_status;
        end
    end

    // minimum stack never holds more entries than the value stack
    a_depth_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mdepth <= r_vdepth)
        else $error("minimum depth exceeds value depth");

    // an accepted item is worked on in the next cycle
    a_acc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> r_busy && !w_in_acc)
        else $error("item not followed by its work cycle");

    // the work cycle always produces a result item
    a_busy_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |=> r_out_valid)
        else $error("work cycle without result item");

    // an empty value stack leaves the minimum stack empty too
    a_empty_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vdepth == '0) |-> (r_mdepth == '0))
        else $error("minimum entries held on empty stack");

endmodule
